// ----- design/rpn_stack_calculator_core_defines.svh -----
// Assertion macros used by the checker of the RPN stack calculator.
`ifndef RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`define RPN_STACK_CALCULATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rpn_pkg.sv -----
`default_nettype none

package rpn_pkg;

    localparam int DATA_W              = 32;
    localparam int ACTION_W            = 3;
    localparam int STATUS_W            = 3;
    localparam int DEPTH_OUT_W         = 5;
    localparam int STACK_DEPTH_DEFAULT = 16;
    localparam int FRAC_BITS_DEFAULT   = 16;

    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_FULL     = 3'd2,
        ST_DIV_ZERO = 3'd3,
        ST_SAT      = 3'd4
    } status_t;

    typedef struct packed {
        logic    start;
        action_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic div_zero;
    } alu_rsp_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } clamp_t;

    // Saturates a double-width two's complement value to the data width.
    function automatic clamp_t clamp_wide(input logic [2*DATA_W-1:0] v);
        clamp_t r;
        logic   upper_same;
        upper_same = (&v[2*DATA_W-1:DATA_W-1]) | ~(|v[2*DATA_W-1:DATA_W-1]);
        if (upper_same) begin
            r.sat   = 1'b0;
            r.value = v[DATA_W-1:0];
        end else begin
            r.sat   = 1'b1;
            r.value = v[2*DATA_W-1] ? DATA_MIN : DATA_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/rpn_stack_calculator_core.sv -----
// Reverse-Polish calculator on a stack of signed fixed-point values with
// FRAC_BITS fraction bits. Each accepted item either pushes s_operand_value
// or pops the top two entries and pushes their sum, difference, product or
// quotient; the top entry is the left operand, so subtract gives top minus
// next and divide gives top over next. Every item returns exactly one result
// with the pushed value (zero when nothing was pushed), a status and the
// stack depth afterwards. Too few operands, a push to a full stack and a
// divide by zero leave the stack unchanged; an overflowing result is
// clamped, pushed and flagged. The block takes one item at a time and
// s_ready is low while an item is in work. A push, a too-few-operands or
// full-stack error or an unknown action, which leaves the stack alone,
// goes straight to the output state. A divide ends early when the divisor
// is zero or the quotient is seen to overflow before the bit loop; else
// multiply and divide run in the shared arithmetic unit, which retires one
// multiplier bit or one quotient bit per cycle over 32 steps. The stack
// lives in a small RAM with one write port and one registered read port,
// so the top operand is read before the lower one. A finished result waits
// in the output register and the next item may be accepted while it
// waits; a second result stalls until the first one has been taken. The
// stack entries have no reset; only entries below the current depth are
// ever read.
`default_nettype none

module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEFAULT,
    parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic        [rpn_pkg::ACTION_W-1:0]      s_action,
    input  wire logic signed [rpn_pkg::DATA_W-1:0]        s_operand_value,
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic signed      [rpn_pkg::DATA_W-1:0]        m_result_value,
    output logic             [rpn_pkg::STATUS_W-1:0]      m_status,
    output logic             [rpn_pkg::DEPTH_OUT_W-1:0]   m_depth_after
);

    localparam int W      = rpn_pkg::DATA_W;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // Sequencer states: read the top entry, then the next one, hand both to
    // the arithmetic unit, wait for it, then present the result.
    typedef enum logic [2:0] {
        T_IDLE,
        T_RD_TOP,
        T_RD_NEXT,
        T_EXEC,
        T_WAIT,
        T_OUT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    rpn_pkg::action_t op_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     res_value_reg;
    rpn_pkg::status_t res_status_reg;
    logic             m_valid_reg;
    logic [W-1:0]     m_value_reg;
    rpn_pkg::status_t m_status_reg;
    logic [rpn_pkg::DEPTH_OUT_W-1:0] m_depth_reg;

    logic              accept;
    logic              out_load;
    logic              stack_full;
    logic              too_few;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  count_m2;
    logic [31:0]       depth_ext;
    logic              push_wr;
    logic              result_wr;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [W-1:0]      ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [W-1:0]      ram_rd_data;

    rpn_pkg::alu_req_t alu_req;
    rpn_pkg::alu_rsp_t alu_rsp;
    logic [W-1:0]      alu_result;

    assign s_ready    = (state_reg == T_IDLE);
    assign accept     = s_valid && s_ready;
    assign stack_full = (count_reg == CNT_W'(STACK_DEPTH));
    assign too_few    = (count_reg < CNT_W'(2));
    assign count_m1   = count_reg - CNT_W'(1);
    assign count_m2   = count_reg - CNT_W'(2);
    assign depth_ext  = 32'(count_reg);

    // The output register takes a new result when it is empty or when its
    // current result leaves in the same cycle.
    assign out_load   = (state_reg == T_OUT) && (!m_valid_reg || m_ready);

    // A push writes at the current depth in the cycle it is accepted. An
    // operation result overwrites the lower operand's slot, which becomes
    // the new top once the count drops by one.
    assign push_wr     = accept && (s_action == rpn_pkg::ACT_PUSH) && !stack_full;
    assign result_wr   = (state_reg == T_WAIT) && alu_rsp.done && !alu_rsp.div_zero;
    assign ram_wr_en   = push_wr || result_wr;
    assign ram_wr_addr = push_wr ? count_reg[ADDR_W-1:0] : count_m2[ADDR_W-1:0];
    assign ram_wr_data = push_wr ? s_operand_value : alu_result;

    assign ram_rd_en   = (state_reg == T_RD_TOP) || (state_reg == T_RD_NEXT);
    assign ram_rd_addr = (state_reg == T_RD_TOP) ? count_m1[ADDR_W-1:0]
                                                 : count_m2[ADDR_W-1:0];

    // The read data still holds the lower operand while the unit starts.
    assign alu_req.start = (state_reg == T_EXEC);
    assign alu_req.op    = op_reg;

    rpn_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rpn_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk    (aclk),
        .rst_n  (aresetn),
        .req    (alu_req),
        .a      (a_reg),
        .b      (ram_rd_data),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        op_reg <= rpn_pkg::action_t'(s_action);
                        case (s_action)
                            rpn_pkg::ACT_PUSH: begin
                                if (stack_full) begin
                                    res_value_reg  <= '0;
                                    res_status_reg <= rpn_pkg::ST_FULL;
                                end else begin
                                    count_reg      <= count_reg + CNT_W'(1);
                                    res_value_reg  <= s_operand_value;
                                    res_status_reg <= rpn_pkg::ST_OK;
                                end
                                state_reg <= T_OUT;
                            end
                            rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB,
                            rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: begin
                                if (too_few) begin
                                    res_value_reg  <= '0;
                                    res_status_reg <= rpn_pkg::ST_FEW;
                                    state_reg      <= T_OUT;
                                end else begin
                                    state_reg <= T_RD_TOP;
                                end
                            end
                            default: begin
                                // Unknown actions leave the stack alone.
                                res_value_reg  <= '0;
                                res_status_reg <= rpn_pkg::ST_OK;
                                state_reg      <= T_OUT;
                            end
                        endcase
                    end
                end
                T_RD_TOP: begin
                    state_reg <= T_RD_NEXT;
                end
                T_RD_NEXT: begin
                    a_reg     <= ram_rd_data;
                    state_reg <= T_EXEC;
                end
                T_EXEC: begin
                    state_reg <= T_WAIT;
                end
                T_WAIT: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.div_zero) begin
                            res_value_reg  <= '0;
                            res_status_reg <= rpn_pkg::ST_DIV_ZERO;
                        end else begin
                            count_reg      <= count_m1;
                            res_value_reg  <= alu_result;
                            res_status_reg <= alu_rsp.sat ? rpn_pkg::ST_SAT
                                                          : rpn_pkg::ST_OK;
                        end
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (out_load) begin
                        m_value_reg  <= res_value_reg;
                        m_status_reg <= res_status_reg;
                        m_depth_reg  <= depth_ext[rpn_pkg::DEPTH_OUT_W-1:0];
                        state_reg    <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_depth_after  = m_depth_reg;

endmodule

`default_nettype wire

// ----- design/rpn_ram.sv -----
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/rpn_alu.sv -----
`default_nettype none

// Iterative arithmetic unit built around one double-width adder. Add and
// subtract take one pass, multiply is radix-2 shift and add, divide is
// restoring with one quotient bit per cycle.
module rpn_alu #(
    parameter int FRAC_BITS = rpn_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rpn_pkg::alu_req_t             req,
    input  wire logic [rpn_pkg::DATA_W-1:0]    a,
    input  wire logic [rpn_pkg::DATA_W-1:0]    b,
    output rpn_pkg::alu_rsp_t                  rsp,
    output logic      [rpn_pkg::DATA_W-1:0]    result
);

    localparam int W     = rpn_pkg::DATA_W;
    localparam int WW    = 2 * W;
    localparam int CNT_W = $clog2(W);

    typedef enum logic [2:0] {
        A_IDLE,
        A_ADD,
        A_MUL,
        A_MUL_FIN,
        A_DIV_CHK,
        A_DIV,
        A_DIV_FIN
    } state_t;

    state_t           state_reg;
    rpn_pkg::action_t op_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [WW-1:0]    acc_reg;
    logic [WW-1:0]    mcand_reg;
    logic [W-1:0]     mplier_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     num_lo_reg;
    logic [W-1:0]     den_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     res_reg;
    logic             done_reg;
    logic             sat_reg;
    logic             dz_reg;

    logic [WW-1:0]     add_x;
    logic [WW-1:0]     add_y;
    logic              add_sub;
    logic [WW-1:0]     add_sum;
    logic [W-1:0]      abs_a;
    logic [W-1:0]      abs_b;
    logic [WW-1:0]     num_wide;
    logic [WW-1:0]     prod_shift;
    rpn_pkg::clamp_t   sum_clamp;
    rpn_pkg::clamp_t   prod_clamp;
    logic              last_step;
    logic              trial_ok;

    assign abs_a      = a[W-1] ? (~a + W'(1)) : a;
    assign abs_b      = b[W-1] ? (~b + W'(1)) : b;
    assign num_wide   = {{W{1'b0}}, abs_a} << FRAC_BITS;
    assign prod_shift = $signed(acc_reg) >>> FRAC_BITS;
    assign last_step  = (cnt_reg == CNT_W'(W - 1));
    assign trial_ok   = ~add_sum[WW-1];

    // The one shared adder; the state picks what it works on.
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            A_ADD: begin
                add_x   = {{W{a_reg[W-1]}}, a_reg};
                add_y   = {{W{b_reg[W-1]}}, b_reg};
                add_sub = (op_reg == rpn_pkg::ACT_SUB);
            end
            A_MUL: begin
                add_x   = acc_reg;
                add_y   = mcand_reg;
                add_sub = last_step;
            end
            A_DIV_CHK: begin
                add_x   = {{W{1'b0}}, rem_reg};
                add_y   = {{W{1'b0}}, den_reg};
                add_sub = 1'b1;
            end
            A_DIV: begin
                add_x   = {{(W-1){1'b0}}, rem_reg, num_lo_reg[W-1]};
                add_y   = {{W{1'b0}}, den_reg};
                add_sub = 1'b1;
            end
            A_DIV_FIN: begin
                add_y   = {{W{1'b0}}, quo_reg};
                add_sub = 1'b1;
            end
            default: begin
            end
        endcase
        add_sum = add_x + (add_sub ? ~add_y : add_y) + WW'(add_sub);
    end

    assign sum_clamp  = rpn_pkg::clamp_wide(add_sum);
    assign prod_clamp = rpn_pkg::clamp_wide(prod_shift);

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        op_reg  <= req.op;
                        a_reg   <= a;
                        b_reg   <= b;
                        sat_reg <= 1'b0;
                        dz_reg  <= 1'b0;
                        case (req.op)
                            rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB: begin
                                state_reg <= A_ADD;
                            end
                            rpn_pkg::ACT_MUL: begin
                                acc_reg    <= '0;
                                mcand_reg  <= {{W{a[W-1]}}, a};
                                mplier_reg <= b;
                                cnt_reg    <= '0;
                                state_reg  <= A_MUL;
                            end
                            rpn_pkg::ACT_DIV: begin
                                if (b == '0) begin
                                    dz_reg   <= 1'b1;
                                    res_reg  <= '0;
                                    done_reg <= 1'b1;
                                end else begin
                                    neg_reg    <= a[W-1] ^ b[W-1];
                                    den_reg    <= abs_b;
                                    rem_reg    <= num_wide[WW-1:W];
                                    num_lo_reg <= num_wide[W-1:0];
                                    state_reg  <= A_DIV_CHK;
                                end
                            end
                            default: begin
                                res_reg  <= '0;
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                A_ADD: begin
                    sat_reg   <= sum_clamp.sat;
                    res_reg   <= sum_clamp.value;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                A_MUL: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= add_sum;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                    if (last_step) begin
                        state_reg <= A_MUL_FIN;
                    end
                end
                A_MUL_FIN: begin
                    sat_reg   <= prod_clamp.sat;
                    res_reg   <= prod_clamp.value;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                A_DIV_CHK: begin
                    // A quotient of 2^W or more cannot fit either way.
                    if (trial_ok) begin
                        sat_reg   <= 1'b1;
                        res_reg   <= neg_reg ? rpn_pkg::DATA_MIN : rpn_pkg::DATA_MAX;
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end else begin
                        cnt_reg   <= '0;
                        quo_reg   <= '0;
                        state_reg <= A_DIV;
                    end
                end
                A_DIV: begin
                    if (trial_ok) begin
                        rem_reg <= add_sum[W-1:0];
                    end else begin
                        rem_reg <= {rem_reg[W-2:0], num_lo_reg[W-1]};
                    end
                    quo_reg    <= {quo_reg[W-2:0], trial_ok};
                    num_lo_reg <= num_lo_reg << 1;
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                    if (last_step) begin
                        state_reg <= A_DIV_FIN;
                    end
                end
                A_DIV_FIN: begin
                    if (neg_reg) begin
                        sat_reg <= quo_reg[W-1] & (|quo_reg[W-2:0]);
                        res_reg <= (quo_reg[W-1] & (|quo_reg[W-2:0])) ?
                                   rpn_pkg::DATA_MIN : add_sum[W-1:0];
                    end else begin
                        sat_reg <= quo_reg[W-1];
                        res_reg <= quo_reg[W-1] ? rpn_pkg::DATA_MAX : quo_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.sat      = sat_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// ----- design/rpn_checker.sv -----
`default_nettype none
`include "rpn_stack_calculator_core_defines.svh"

module rpn_checker (
    input wire logic                                     aclk,
    input wire logic                                     aresetn,
    input wire logic                                     s_valid,
    input wire logic                                     s_ready,
    input wire logic        [rpn_pkg::ACTION_W-1:0]      s_action,
    input wire logic signed [rpn_pkg::DATA_W-1:0]        s_operand_value,
    input wire logic                                     m_valid,
    input wire logic                                     m_ready,
    input wire logic signed [rpn_pkg::DATA_W-1:0]        m_result_value,
    input wire logic        [rpn_pkg::STATUS_W-1:0]      m_status,
    input wire logic        [rpn_pkg::DEPTH_OUT_W-1:0]   m_depth_after
);

    // Only one item is in work at a time.
    `RPN_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "item accepted while busy")

    // A new result only appears after the block has been busy with an item.
    `RPN_ASSERT_NOW(a_result_after_work, aclk, aresetn, $rose(m_valid), $past(!s_ready), "result without work")

    // A stalled result holds.
    `RPN_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_value) && $stable(m_status) && $stable(m_depth_after), "stalled result changed")

    // Error results (too few, full, divide by zero) report a zero value.
    `RPN_ASSERT_NOW(a_error_zero, aclk, aresetn, m_valid && (m_status == rpn_pkg::ST_FEW || m_status == rpn_pkg::ST_FULL || m_status == rpn_pkg::ST_DIV_ZERO), m_result_value == '0, "error result not zero")

endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_action        (s_action),
    .s_operand_value (s_operand_value),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_value  (m_result_value),
    .m_status        (m_status),
    .m_depth_after   (m_depth_after)
);

`default_nettype wire
